// File: rtl/core/idea_block_cipher_macros.svh
// assertion macros for the idea block cipher core
// included by files that carry concurrent checks, no other dependencies
`ifndef IDEA_BLOCK_CIPHER_MACROS_SVH
`define IDEA_BLOCK_CIPHER_MACROS_SVH

`ifndef SYNTHESIS
`define IDEA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("idea check failed");
`define IDEA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("idea check failed");
`else
`define IDEA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define IDEA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/idea_pkg.sv
// shared types, constants and address functions for the idea block cipher
// no dependencies
`default_nettype none
package idea_pkg;

   localparam int ROUNDS    = 8;
   localparam int SUBKEYS   = 6 * ROUNDS + 4;
   localparam int WORD_W    = 16;
   localparam int BLOCK_W   = 4 * WORD_W;
   localparam int KEY_W     = 8 * WORD_W;
   localparam int KEY_AW    = $clog2(SUBKEYS);
   localparam int MEM_AW    = KEY_AW + 1;
   localparam int MEM_DEPTH = 2 ** MEM_AW;
   localparam int RND_W     = $clog2(ROUNDS + 1);
   localparam int MOD_MUL   = 65537;
   localparam int KEY_ROT   = 25;
   localparam int INV_MULS  = 2 * (WORD_W - 1);
   localparam int INV_W     = $clog2(INV_MULS + 1);

   typedef enum logic [1:0] {
      CSR_KEY_UPPER = 2'd0,
      CSR_KEY_LOWER = 2'd1,
      CSR_DECRYPT   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_EXPAND,
      PH_DEC_RD,
      PH_DEC_OP,
      PH_DEC_INV,
      PH_ROUND
   } phase_type;

   typedef enum logic [3:0] {
      ST_K0,
      ST_MUL1,
      ST_MUL4,
      ST_ADD2,
      ST_ADD3,
      ST_MA,
      ST_T0,
      ST_MB,
      ST_MIX
   } step_type;

   typedef enum logic [1:0] {
      DOP_INV,
      DOP_NEG,
      DOP_COPY
   } dop_type;

   function automatic logic [MEM_AW-1:0] key_addr(input logic region,
                                                  input logic [RND_W-1:0] rnd,
                                                  input logic [2:0] off);
      logic [KEY_AW-1:0] a;
      a = KEY_AW'(rnd) * KEY_AW'(6) + KEY_AW'(off);
      return {region, a};
   endfunction

   function automatic logic [KEY_AW-1:0] dec_src(input logic [RND_W-1:0] i,
                                                 input logic [2:0] m);
      logic [KEY_AW-1:0] s;
      logic              edge_rnd;
      s = (KEY_AW'(ROUNDS) - KEY_AW'(i)) * KEY_AW'(6);
      edge_rnd = (i == '0) || (i == RND_W'(ROUNDS));
      case (m)
         3'd0:    return s;
         3'd1:    return s + (edge_rnd ? KEY_AW'(1) : KEY_AW'(2));
         3'd2:    return s + (edge_rnd ? KEY_AW'(2) : KEY_AW'(1));
         3'd3:    return s + KEY_AW'(3);
         3'd4:    return s - KEY_AW'(2);
         default: return s - KEY_AW'(1);
      endcase
   endfunction

   function automatic dop_type dec_op(input logic [2:0] m);
      case (m)
         3'd0, 3'd3: return DOP_INV;
         3'd1, 3'd2: return DOP_NEG;
         default:    return DOP_COPY;
      endcase
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/idea_mulmod.sv
// shared multiplier modulo 65537, word 0 standing for 65536
// product registered, reduction on the register output; uses idea_pkg
`default_nettype none
module idea_mulmod (
   input  wire logic                        clock,
   input  wire logic [idea_pkg::WORD_W-1:0] a_i,
   input  wire logic [idea_pkg::WORD_W-1:0] b_i,
   output logic      [idea_pkg::WORD_W-1:0] res_o
);

   localparam int EW = idea_pkg::WORD_W + 1;
   localparam int PW = 2 * idea_pkg::WORD_W + 1;

   logic [EW-1:0]               ea;
   logic [EW-1:0]               eb;
   logic [PW-1:0]               product_ff;
   logic [PW-1:0]               product_in;
   logic [EW-1:0]               hi;
   logic [idea_pkg::WORD_W-1:0] lo;

   assign ea = (a_i == '0) ? EW'(2 ** idea_pkg::WORD_W) : {1'b0, a_i};
   assign eb = (b_i == '0) ? EW'(2 ** idea_pkg::WORD_W) : {1'b0, b_i};
   assign product_in = PW'({{EW{1'b0}}, ea} * {{EW{1'b0}}, eb});

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign hi = product_ff[PW-1:idea_pkg::WORD_W];
   assign lo = product_ff[idea_pkg::WORD_W-1:0];

   always_comb begin
      if ({1'b0, lo} >= hi) begin
         res_o = lo - hi[idea_pkg::WORD_W-1:0];
      end else begin
         res_o = idea_pkg::WORD_W'((EW+1)'({2'b00, lo}) + (EW+1)'(idea_pkg::MOD_MUL)
                                   - (EW+1)'({1'b0, hi}));
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/idea_block_cipher.sv
// idea block cipher top level: sequencer, subkey memory and round datapath
// uses idea_pkg, idea_mulmod and idea_block_cipher_macros.svh
//
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_block_in[63:0]
// rsp     | out       | rsp_valid/rsp_stall  | rsp_block_out[63:0]
// csr     | in        | csr_valid/csr_ready  | csr_index[1:0], csr_wdata[63:0]
//
// a block runs a key fetch, then the steps of each round on the shared mod-65537
// multiplier, then the output transform, and goes back to idle
// after reset or a key or mode write the next block first runs subkey expansion
// of all 52 subkeys, followed by subkey inversion in decrypt mode
// req_stall is high while a block is at work or csr_valid is high; a finished result
// waits in the output register, and the next one holds until it has left
`default_nettype none
`include "idea_block_cipher_macros.svh"
module idea_block_cipher (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [idea_pkg::BLOCK_W-1:0] req_block_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [idea_pkg::BLOCK_W-1:0] rsp_block_out,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [idea_pkg::BLOCK_W-1:0] csr_wdata
);

   localparam int W = idea_pkg::WORD_W;

   idea_pkg::phase_type            phase_ff, phase_in;
   idea_pkg::step_type             step_ff, step_in;
   logic [idea_pkg::RND_W-1:0]     round_ff, round_in;
   logic [W-1:0]                   x1_ff, x1_in, x2_ff, x2_in;
   logic [W-1:0]                   x3_ff, x3_in, x4_ff, x4_in;
   logic [W-1:0]                   t0_ff, t0_in;
   logic [W-1:0]                   base_ff, base_in;
   logic [idea_pkg::INV_W-1:0]     inv_cnt_ff, inv_cnt_in;
   logic [idea_pkg::KEY_AW-1:0]    cnt_ff, cnt_in;
   logic [idea_pkg::RND_W-1:0]     dec_i_ff, dec_i_in;
   logic [2:0]                     dec_m_ff, dec_m_in;
   logic [idea_pkg::KEY_W-1:0]     rot_ff, rot_in;
   logic [idea_pkg::BLOCK_W-1:0]   key_upper_ff, key_upper_in;
   logic [idea_pkg::BLOCK_W-1:0]   key_lower_ff, key_lower_in;
   logic                           decrypt_ff, decrypt_in;
   logic                           sched_valid_ff, sched_valid_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [idea_pkg::BLOCK_W-1:0]   rsp_block_ff, rsp_block_in;

   logic [W-1:0]                   mem [idea_pkg::MEM_DEPTH];
   logic [W-1:0]                   rd_ff;
   logic [idea_pkg::MEM_AW-1:0]    raddr;
   logic [idea_pkg::MEM_AW-1:0]    waddr;
   logic [W-1:0]                   wdata;
   logic                           we;

   logic [W-1:0]                   mul_a, mul_b, mul_res;
   logic [W-1:0]                   t1, t0n;
   logic                           req_acc, csr_acc, out_free, fin, exp_last;
   logic                           dec_last_m, dec_final, dec_done;
   idea_pkg::dop_type              dop;

   idea_mulmod u_mul (
      .clock (clock),
      .a_i   (mul_a),
      .b_i   (mul_b),
      .res_o (mul_res)
   );

   assign req_stall     = (phase_ff != idea_pkg::PH_IDLE) || csr_valid;
   assign csr_ready     = (phase_ff == idea_pkg::PH_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_block_ff;

   assign req_acc    = req_valid && !req_stall;
   assign csr_acc    = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fin        = (phase_ff == idea_pkg::PH_ROUND) && (step_ff == idea_pkg::ST_ADD3)
                       && (round_ff == idea_pkg::RND_W'(idea_pkg::ROUNDS));
   assign exp_last   = (cnt_ff == idea_pkg::KEY_AW'(idea_pkg::SUBKEYS - 1));
   assign dop        = idea_pkg::dec_op(dec_m_ff);
   assign dec_last_m = (dec_i_ff == idea_pkg::RND_W'(idea_pkg::ROUNDS)) ?
                       (dec_m_ff == 3'd3) : (dec_m_ff == 3'd5);
   assign dec_final  = dec_last_m && (dec_i_ff == idea_pkg::RND_W'(idea_pkg::ROUNDS));
   assign dec_done   = ((phase_ff == idea_pkg::PH_DEC_OP) && (dop != idea_pkg::DOP_INV))
                       || ((phase_ff == idea_pkg::PH_DEC_INV)
                           && (inv_cnt_ff == idea_pkg::INV_W'(idea_pkg::INV_MULS)));
   assign t1         = mul_res;
   assign t0n        = t0_ff + t1;

   // next state
   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      unique case (phase_ff)
         idea_pkg::PH_IDLE: begin
            if (req_acc) begin
               phase_in = sched_valid_ff ? idea_pkg::PH_ROUND : idea_pkg::PH_EXPAND;
               step_in  = idea_pkg::ST_K0;
            end
         end
         idea_pkg::PH_EXPAND: begin
            if (exp_last) begin
               phase_in = decrypt_ff ? idea_pkg::PH_DEC_RD : idea_pkg::PH_ROUND;
            end
         end
         idea_pkg::PH_DEC_RD: begin
            phase_in = idea_pkg::PH_DEC_OP;
         end
         idea_pkg::PH_DEC_OP, idea_pkg::PH_DEC_INV: begin
            if (phase_ff == idea_pkg::PH_DEC_OP && dop == idea_pkg::DOP_INV) begin
               phase_in = idea_pkg::PH_DEC_INV;
            end else if (dec_done) begin
               phase_in = dec_final ? idea_pkg::PH_ROUND : idea_pkg::PH_DEC_RD;
            end
         end
         idea_pkg::PH_ROUND: begin
            unique case (step_ff)
               idea_pkg::ST_K0:   step_in = idea_pkg::ST_MUL1;
               idea_pkg::ST_MUL1: step_in = idea_pkg::ST_MUL4;
               idea_pkg::ST_MUL4: step_in = idea_pkg::ST_ADD2;
               idea_pkg::ST_ADD2: step_in = idea_pkg::ST_ADD3;
               idea_pkg::ST_ADD3: begin
                  if (!fin) begin
                     step_in = idea_pkg::ST_MA;
                  end else if (out_free) begin
                     phase_in = idea_pkg::PH_IDLE;
                  end
               end
               idea_pkg::ST_MA:   step_in = idea_pkg::ST_T0;
               idea_pkg::ST_T0:   step_in = idea_pkg::ST_MB;
               idea_pkg::ST_MB:   step_in = idea_pkg::ST_MIX;
               idea_pkg::ST_MIX:  step_in = idea_pkg::ST_MUL1;
               default:           step_in = idea_pkg::ST_K0;
            endcase
         end
         default: phase_in = idea_pkg::PH_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      round_in       = round_ff;
      x1_in          = x1_ff;
      x2_in          = x2_ff;
      x3_in          = x3_ff;
      x4_in          = x4_ff;
      t0_in          = t0_ff;
      base_in        = base_ff;
      inv_cnt_in     = inv_cnt_ff;
      cnt_in         = cnt_ff;
      dec_i_in       = dec_i_ff;
      dec_m_in       = dec_m_ff;
      rot_in         = rot_ff;
      key_upper_in   = key_upper_ff;
      key_lower_in   = key_lower_ff;
      decrypt_in     = decrypt_ff;
      sched_valid_in = sched_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_block_in   = rsp_block_ff;
      raddr          = idea_pkg::key_addr(decrypt_ff, round_ff, 3'd0);
      waddr          = idea_pkg::key_addr(1'b1, dec_i_ff, dec_m_ff);
      wdata          = rd_ff;
      we             = 1'b0;
      mul_a          = x1_ff;
      mul_b          = rd_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_acc) begin
         unique case (idea_pkg::csr_index_type'(csr_index))
            idea_pkg::CSR_KEY_UPPER: begin
               key_upper_in   = csr_wdata;
               sched_valid_in = 1'b0;
            end
            idea_pkg::CSR_KEY_LOWER: begin
               key_lower_in   = csr_wdata;
               sched_valid_in = 1'b0;
            end
            idea_pkg::CSR_DECRYPT: begin
               decrypt_in     = csr_wdata[0];
               sched_valid_in = 1'b0;
            end
            default: ;
         endcase
      end

      unique case (phase_ff)
         idea_pkg::PH_IDLE: begin
            if (req_acc) begin
               x1_in    = req_block_in[4*W-1:3*W];
               x2_in    = req_block_in[3*W-1:2*W];
               x3_in    = req_block_in[2*W-1:W];
               x4_in    = req_block_in[W-1:0];
               round_in = '0;
               cnt_in   = '0;
               dec_i_in = '0;
               dec_m_in = '0;
               rot_in   = {key_upper_ff, key_lower_ff};
            end
         end
         idea_pkg::PH_EXPAND: begin
            we     = 1'b1;
            waddr  = {1'b0, cnt_ff};
            wdata  = rot_ff[idea_pkg::KEY_W-1 -: W];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[2:0] == 3'd7) begin
               rot_in = {rot_ff[idea_pkg::KEY_W-1-(W+idea_pkg::KEY_ROT):0],
                         rot_ff[idea_pkg::KEY_W-1 -: (W+idea_pkg::KEY_ROT)]};
            end else begin
               rot_in = {rot_ff[idea_pkg::KEY_W-1-W:0], rot_ff[idea_pkg::KEY_W-1 -: W]};
            end
            if (exp_last && !decrypt_ff) begin
               sched_valid_in = 1'b1;
            end
         end
         idea_pkg::PH_DEC_RD: begin
            raddr = {1'b0, idea_pkg::dec_src(dec_i_ff, dec_m_ff)};
         end
         idea_pkg::PH_DEC_OP, idea_pkg::PH_DEC_INV: begin
            if (phase_ff == idea_pkg::PH_DEC_OP) begin
               base_in    = rd_ff;
               mul_a      = rd_ff;
               mul_b      = rd_ff;
               inv_cnt_in = idea_pkg::INV_W'(1);
               if (dop == idea_pkg::DOP_NEG) begin
                  wdata = W'(0) - rd_ff;
               end
            end else begin
               wdata      = mul_res;
               mul_a      = mul_res;
               mul_b      = inv_cnt_ff[0] ? base_ff : mul_res;
               inv_cnt_in = inv_cnt_ff + 1'b1;
            end
            if (dec_done) begin
               we = 1'b1;
               if (dec_last_m) begin
                  dec_m_in = '0;
                  dec_i_in = dec_i_ff + 1'b1;
               end else begin
                  dec_m_in = dec_m_ff + 3'd1;
               end
               if (dec_final) begin
                  sched_valid_in = 1'b1;
               end
            end
         end
         idea_pkg::PH_ROUND: begin
            case (step_ff)
               idea_pkg::ST_K0: begin
                  raddr = idea_pkg::key_addr(decrypt_ff, round_ff, 3'd0);
               end
               idea_pkg::ST_MUL1: begin
                  mul_a = x1_ff;
                  raddr = idea_pkg::key_addr(decrypt_ff, round_ff, 3'd3);
               end
               idea_pkg::ST_MUL4: begin
                  x1_in = mul_res;
                  mul_a = x4_ff;
                  raddr = idea_pkg::key_addr(decrypt_ff, round_ff, 3'd1);
               end
               idea_pkg::ST_ADD2: begin
                  x4_in = mul_res;
                  x2_in = x2_ff + rd_ff;
                  raddr = idea_pkg::key_addr(decrypt_ff, round_ff, 3'd2);
               end
               idea_pkg::ST_ADD3: begin
                  if (!fin) begin
                     x3_in = x3_ff + rd_ff;
                     raddr = idea_pkg::key_addr(decrypt_ff, round_ff, 3'd4);
                  end else begin
                     raddr = idea_pkg::key_addr(decrypt_ff, round_ff, 3'd2);
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_block_in = {x1_ff, x2_ff, x3_ff + rd_ff, x4_ff};
                     end
                  end
               end
               idea_pkg::ST_MA: begin
                  mul_a = x1_ff ^ x3_ff;
                  raddr = idea_pkg::key_addr(decrypt_ff, round_ff, 3'd5);
               end
               idea_pkg::ST_T0: begin
                  t0_in = mul_res;
                  raddr = idea_pkg::key_addr(decrypt_ff, round_ff, 3'd5);
               end
               idea_pkg::ST_MB: begin
                  mul_a = (x2_ff ^ x4_ff) + t0_ff;
               end
               idea_pkg::ST_MIX: begin
                  x1_in    = x1_ff ^ t1;
                  x4_in    = x4_ff ^ t0n;
                  round_in = round_ff + 1'b1;
                  raddr    = idea_pkg::key_addr(decrypt_ff, round_ff + 1'b1, 3'd0);
                  if (round_ff < idea_pkg::RND_W'(idea_pkg::ROUNDS - 1)) begin
                     x2_in = x3_ff ^ t1;
                     x3_in = x2_ff ^ t0n;
                  end else begin
                     x2_in = x2_ff ^ t0n;
                     x3_in = x3_ff ^ t1;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= idea_pkg::PH_IDLE;
         step_ff        <= idea_pkg::ST_K0;
         round_ff       <= '0;
         inv_cnt_ff     <= '0;
         cnt_ff         <= '0;
         dec_i_ff       <= '0;
         dec_m_ff       <= '0;
         key_upper_ff   <= '0;
         key_lower_ff   <= '0;
         decrypt_ff     <= 1'b0;
         sched_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         step_ff        <= step_in;
         round_ff       <= round_in;
         inv_cnt_ff     <= inv_cnt_in;
         cnt_ff         <= cnt_in;
         dec_i_ff       <= dec_i_in;
         dec_m_ff       <= dec_m_in;
         key_upper_ff   <= key_upper_in;
         key_lower_ff   <= key_lower_in;
         decrypt_ff     <= decrypt_in;
         sched_valid_ff <= sched_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff        <= x1_in;
      x2_ff        <= x2_in;
      x3_ff        <= x3_in;
      x4_ff        <= x4_in;
      t0_ff        <= t0_in;
      base_ff      <= base_in;
      rot_ff       <= rot_in;
      rsp_block_ff <= rsp_block_in;
   end

   `IDEA_ASSERT_NEXT(a_finish_loads_rsp, clock, reset, fin && out_free, rsp_valid_ff && (phase_ff == idea_pkg::PH_IDLE))
   `IDEA_ASSERT_IMPL(a_round_needs_sched, clock, reset, phase_ff == idea_pkg::PH_ROUND, sched_valid_ff)
   `IDEA_ASSERT_IMPL(a_round_in_range, clock, reset, 1'b1, round_ff <= idea_pkg::RND_W'(idea_pkg::ROUNDS))

endmodule
`default_nettype wire
